### design/bcu_pkg.sv
// Types and constants shared by the binomial coefficient unit.
package bcu_pkg;

	localparam int OPND_W     = 8;
	localparam int COEF_W     = 63;
	localparam int PROD_W     = 72;
	localparam int DIGIT_W    = 8;
	localparam int DIV_CYCLES = PROD_W / DIGIT_W;
	localparam int CNT_W      = $clog2(DIV_CYCLES);

	localparam logic [COEF_W-1:0] COEF_LIMIT = {COEF_W{1'b1}};

	typedef struct packed {
		logic [OPND_W-1:0] n_value;
		logic [OPND_W-1:0] k_value;
	} item_in_t;

	typedef struct packed {
		logic [COEF_W-1:0] coefficient;
		logic              overflow;
	} item_out_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [OPND_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

### design/bcu_divider.sv
// Sequential divider: restoring division, eight quotient bits per cycle.
module bcu_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  bcu_pkg::div_req_t req,
	output bcu_pkg::div_rsp_t rsp
);

	logic [bcu_pkg::PROD_W-1:0] work_q;
	logic [bcu_pkg::OPND_W-1:0] div_q;
	logic [bcu_pkg::OPND_W-1:0] rem_q;
	logic [bcu_pkg::CNT_W-1:0]  cnt_q;
	logic                       run_q;
	logic                       done_q;

	logic [bcu_pkg::PROD_W-1:0] work_d;
	logic [bcu_pkg::OPND_W-1:0] rem_d;
	logic [bcu_pkg::OPND_W:0]   part;

	// Shift the dividend out MSB first; quotient bits enter at the bottom.
	always_comb begin
		work_d = work_q;
		rem_d  = rem_q;
		part   = '0;
		for (int j = 0; j < bcu_pkg::DIGIT_W; j++) begin
			part   = {rem_d, work_d[bcu_pkg::PROD_W-1]};
			work_d = {work_d[bcu_pkg::PROD_W-2:0], 1'b0};
			if (part >= {1'b0, div_q}) begin
				part      = part - {1'b0, div_q};
				work_d[0] = 1'b1;
			end
			rem_d = part[bcu_pkg::OPND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == bcu_pkg::CNT_W'(bcu_pkg::DIV_CYCLES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			div_q  <= req.divisor;
			rem_q  <= '0;
		end else if (run_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q;

endmodule

### design/binomial_coefficient_unit.sv
// Binomial coefficient unit: C(n,k) by repeated multiply and exact divide.
// Early result when k > n, n > MAX_N or min(k, n-k) = 0; otherwise m = min(k, n-k)
// multiply-and-divide steps run, ending early on overflow.
// Each step is a multiply state (S_MUL), then the divider in S_DIV, then the hand-back.
// One transaction at a time: busy stays high until the result strobe; no stall.
// Reset (arst_n low) returns the sequencer to idle and drops busy and done.
module binomial_coefficient_unit #(
	parameter int MAX_N = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bcu_pkg::item_in_t  operand,
	output logic               done,
	output bcu_pkg::item_out_t result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	localparam logic [16:0] MAX_N_L = 17'(MAX_N);

	logic [1:0]                 state_q;
	logic [bcu_pkg::OPND_W-1:0] n_q;
	logic [bcu_pkg::OPND_W-1:0] m_q;
	logic [bcu_pkg::OPND_W-1:0] i_q;
	logic [bcu_pkg::COEF_W-1:0] prev_q;
	logic                       done_q;
	bcu_pkg::item_out_t         result_q;

	logic [bcu_pkg::OPND_W-1:0] diff;
	logic [bcu_pkg::OPND_W-1:0] m_new;
	logic [bcu_pkg::OPND_W-1:0] i_next;
	logic [bcu_pkg::OPND_W-1:0] factor;
	logic                       accept;
	bcu_pkg::div_req_t          div_req;
	bcu_pkg::div_rsp_t          div_rsp;

	assign accept = start && (state_q == S_IDLE);
	assign diff   = operand.n_value - operand.k_value;
	assign m_new  = (operand.k_value < diff) ? operand.k_value : diff;
	assign i_next = i_q + 1'b1;
	assign factor = n_q - i_q;

	// prev * (n - i) is always a multiple of i + 1.
	assign div_req.start    = (state_q == S_MUL);
	assign div_req.dividend = bcu_pkg::PROD_W'(prev_q) * bcu_pkg::PROD_W'(factor);
	assign div_req.divisor  = i_next;

	bcu_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ({9'd0, operand.n_value} > MAX_N_L) begin
							done_q <= 1'b1;
						end else if (operand.k_value > operand.n_value) begin
							done_q <= 1'b1;
						end else if (m_new == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if ((|div_rsp.quotient[bcu_pkg::PROD_W-1:bcu_pkg::COEF_W])
								|| (i_next == m_q)) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q    <= operand.n_value;
			m_q    <= m_new;
			i_q    <= '0;
			prev_q <= bcu_pkg::COEF_W'(1);
			if ({9'd0, operand.n_value} > MAX_N_L) begin
				result_q.coefficient <= '0;
				result_q.overflow    <= 1'b1;
			end else if (operand.k_value > operand.n_value) begin
				result_q.coefficient <= '0;
				result_q.overflow    <= 1'b0;
			end else begin
				result_q.coefficient <= bcu_pkg::COEF_W'(1);
				result_q.overflow    <= 1'b0;
			end
		end else if ((state_q == S_DIV) && div_rsp.done) begin
			prev_q <= div_rsp.quotient[bcu_pkg::COEF_W-1:0];
			i_q    <= i_next;
			// Values only grow from here, so stop at the first one past the limit.
			if (|div_rsp.quotient[bcu_pkg::PROD_W-1:bcu_pkg::COEF_W]) begin
				result_q.coefficient <= bcu_pkg::COEF_LIMIT;
				result_q.overflow    <= 1'b1;
			end else begin
				result_q.coefficient <= div_rsp.quotient[bcu_pkg::COEF_W-1:0];
				result_q.overflow    <= 1'b0;
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

### design/bcu_checker.sv
// Port-level checker for the binomial coefficient unit, with its bind.
module bcu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input bcu_pkg::item_out_t result
);

	// An accepted transaction is either under way or answered on the next cycle.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither busy nor answered");

	// Busy drops only together with a result strobe.
	a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (busy || done))
		else $error("busy dropped without a result");

	// The result strobe is never shown while a transaction is still in work.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Overflow pairs with saturation or with the rejection code.
	a_overflow_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.overflow) |->
			((result.coefficient == bcu_pkg::COEF_LIMIT) || (result.coefficient == '0)))
		else $error("overflow with unexpected coefficient");

endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
